[src/hbad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbad_pkg
// Shared types and constants for the handheld bus address decoder.
// ----------------------------------------------------------------------------
package hbad_pkg;

	localparam int unsigned ADDR_W   = 16;
	localparam int unsigned DATA_W   = 16;
	localparam int unsigned BYTE_W   = 8;
	localparam int unsigned TADDR_W  = 23;
	localparam int unsigned LOC_W    = 15;
	localparam int unsigned EXT_W    = 17;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned CFG_W    = 23;

	localparam int unsigned FUNC_WRITE_BIT = 0;
	localparam int unsigned FUNC_WORD_BIT  = 1;

	localparam logic [CFG_IDX_W-1:0] REG_ROM_BANK_OFFSET = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXT_RAM_OFFSET  = 2'd1;

	localparam logic [CFG_W-1:0] ROM_OFFSET_RESET = 23'h004000;
	localparam logic [EXT_W-1:0] EXT_OFFSET_RESET = 17'h00000;

	localparam logic [ADDR_W-1:0] ADDR_ROM_BANKED = 16'h4000;
	localparam logic [ADDR_W-1:0] ADDR_VRAM       = 16'h8000;
	localparam logic [ADDR_W-1:0] ADDR_EXT_RAM    = 16'hA000;
	localparam logic [ADDR_W-1:0] ADDR_WRAM       = 16'hC000;
	localparam logic [ADDR_W-1:0] ADDR_ECHO       = 16'hE000;
	localparam logic [ADDR_W-1:0] ADDR_OAM        = 16'hFE00;
	localparam logic [ADDR_W-1:0] ADDR_UNUSABLE   = 16'hFEA0;
	localparam logic [ADDR_W-1:0] ADDR_IO         = 16'hFF00;
	localparam logic [ADDR_W-1:0] ADDR_VIDEO      = 16'hFF40;
	localparam logic [ADDR_W-1:0] ADDR_VIDEO_END  = 16'hFF4C;
	localparam logic [ADDR_W-1:0] ADDR_HRAM       = 16'hFF80;
	localparam logic [ADDR_W-1:0] ADDR_IE         = 16'hFFFF;

	localparam logic [BYTE_W-1:0] IO_JOYPAD = 8'h00;
	localparam logic [BYTE_W-1:0] IO_SB     = 8'h01;
	localparam logic [BYTE_W-1:0] IO_SC     = 8'h02;
	localparam logic [BYTE_W-1:0] IO_DIV    = 8'h04;
	localparam logic [BYTE_W-1:0] IO_TIMA   = 8'h05;
	localparam logic [BYTE_W-1:0] IO_TMA    = 8'h06;
	localparam logic [BYTE_W-1:0] IO_TAC    = 8'h07;
	localparam logic [BYTE_W-1:0] IO_IF     = 8'h0F;

	localparam logic [BYTE_W-1:0] READ_HOLE   = 8'hFF;
	localparam logic [BYTE_W-1:0] READ_UNIMPL = 8'h00;

	typedef enum logic [4:0] {
		TGT_ROM_FIXED  = 5'd0,
		TGT_ROM_BANKED = 5'd1,
		TGT_BANK_CTRL  = 5'd2,
		TGT_VRAM       = 5'd3,
		TGT_EXT_RAM    = 5'd4,
		TGT_WRAM       = 5'd5,
		TGT_OAM        = 5'd6,
		TGT_JOYPAD     = 5'd7,
		TGT_SERIAL     = 5'd8,
		TGT_IF         = 5'd9,
		TGT_DIV        = 5'd10,
		TGT_TIMA       = 5'd11,
		TGT_TMA        = 5'd12,
		TGT_TAC        = 5'd13,
		TGT_VIDEO      = 5'd14,
		TGT_HRAM       = 5'd15,
		TGT_IE         = 5'd16,
		TGT_NONE       = 5'd17
	} tgt_t;

	typedef struct packed {
		tgt_t              tgt;
		logic [LOC_W-1:0]  loc;
		logic              is_write;
		logic [BYTE_W-1:0] byte_data;
		logic [BYTE_W-1:0] read_constant;
		logic              last;
	} beat_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

[src/hbad_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbad_front
// Accepts bus accesses, splits word accesses into two byte beats and
// classifies each beat by address region before queueing it.
// ----------------------------------------------------------------------------
module hbad_front
	import hbad_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [1:0]          func,
	input  logic [ADDR_W-1:0]   address,
	input  logic [DATA_W-1:0]   write_data,
	input  q_status_t           q_status,
	output logic                q_push,
	output beat_t               q_data
);

	logic              pend_q;
	logic [ADDR_W-1:0] pend_addr_q;
	logic [BYTE_W-1:0] pend_data_q;
	logic              pend_wr_q;

	logic              accept;
	logic [ADDR_W-1:0] beat_addr;
	logic [BYTE_W-1:0] beat_data;
	logic              beat_wr;
	logic              beat_last;

	function automatic beat_t classify(
		input logic [ADDR_W-1:0] addr,
		input logic              wr,
		input logic [BYTE_W-1:0] data,
		input logic              fin
	);
		beat_t b;
		b.tgt           = TGT_NONE;
		b.loc           = '0;
		b.read_constant = READ_UNIMPL;
		if (addr < ADDR_ROM_BANKED) begin
			b.tgt = wr ? TGT_BANK_CTRL : TGT_ROM_FIXED;
			b.loc = addr[LOC_W-1:0];
		end else if (addr < ADDR_VRAM) begin
			if (wr) begin
				b.tgt = TGT_BANK_CTRL;
				b.loc = addr[LOC_W-1:0];
			end else begin
				b.tgt = TGT_ROM_BANKED;
				b.loc = {1'b0, addr[13:0]};
			end
		end else if (addr < ADDR_EXT_RAM) begin
			b.tgt = TGT_VRAM;
			b.loc = {2'b00, addr[12:0]};
		end else if (addr < ADDR_WRAM) begin
			b.tgt = TGT_EXT_RAM;
			b.loc = {2'b00, addr[12:0]};
		end else if (addr < ADDR_OAM) begin
			b.tgt = TGT_WRAM;
			b.loc = {2'b00, addr[12:0]};
		end else if (addr < ADDR_UNUSABLE) begin
			b.tgt = TGT_OAM;
			b.loc = {7'd0, addr[7:0]};
		end else if (addr < ADDR_IO) begin
			b.read_constant = READ_HOLE;
		end else if (addr < ADDR_VIDEO) begin
			unique case (addr[7:0]) inside
				IO_JOYPAD: b.tgt = TGT_JOYPAD;
				IO_SB, IO_SC: begin
					b.tgt = TGT_SERIAL;
					b.loc = {14'd0, addr[1]};
				end
				IO_DIV:  b.tgt = TGT_DIV;
				IO_TIMA: b.tgt = TGT_TIMA;
				IO_TMA:  b.tgt = TGT_TMA;
				IO_TAC:  b.tgt = TGT_TAC;
				IO_IF:   b.tgt = TGT_IF;
				default: b.read_constant = READ_UNIMPL;
			endcase
		end else if (addr < ADDR_VIDEO_END) begin
			b.tgt = TGT_VIDEO;
			b.loc = {11'd0, addr[3:0]};
		end else if (addr < ADDR_HRAM) begin
			b.read_constant = READ_HOLE;
		end else if (addr < ADDR_IE) begin
			b.tgt = TGT_HRAM;
			b.loc = {8'd0, addr[6:0]};
		end else begin
			b.tgt = TGT_IE;
		end
		b.is_write  = wr && (b.tgt != TGT_NONE);
		b.byte_data = b.is_write ? data : '0;
		b.last      = fin;
		return b;
	endfunction

	assign in_stall = pend_q | q_status.full;
	assign accept   = in_valid & ~in_stall;

	always_comb begin
		if (pend_q) begin
			beat_addr = pend_addr_q;
			beat_data = pend_data_q;
			beat_wr   = pend_wr_q;
			beat_last = 1'b1;
		end else begin
			beat_addr = address;
			beat_data = write_data[BYTE_W-1:0];
			beat_wr   = func[FUNC_WRITE_BIT];
			beat_last = ~func[FUNC_WORD_BIT];
		end
	end

	assign q_push = (accept | pend_q) & ~q_status.full;
	assign q_data = classify(beat_addr, beat_wr, beat_data, beat_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (accept) begin
			pend_q <= func[FUNC_WORD_BIT];
		end else if (q_push) begin
			pend_q <= 1'b0;
		end
	end

	// hold the high byte of a word access for the following beat
	always_ff @(posedge clk) begin
		if (accept) begin
			pend_addr_q <= address + ADDR_W'(1);
			pend_data_q <= write_data[DATA_W-1:BYTE_W];
			pend_wr_q   <= func[FUNC_WRITE_BIT];
		end
	end

endmodule

[src/hbad_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbad_fifo
// Short beat queue between the classifying front and the address back end.
// ----------------------------------------------------------------------------
module hbad_fifo
	import hbad_pkg::*;
#(
	parameter int unsigned DEPTH = 4
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  beat_t     push_data,
	input  logic      pop,
	output beat_t     pop_data,
	output q_status_t status
);

	localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	beat_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign status.full  = (count_q == CW'(DEPTH));
	assign status.empty = (count_q == '0);
	assign pop_data     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + CW'(1);
				2'b01:   count_q <= count_q - CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[src/hbad_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbad_back
// Holds the bank offset registers, applies them to queued beats and drives
// the registered result channel.
// ----------------------------------------------------------------------------
module hbad_back
	import hbad_pkg::*;
#(
	parameter int unsigned ROM_ADDR_BITS = 23
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  q_status_t            q_status,
	input  beat_t                q_data,
	output logic                 q_pop,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [4:0]           target,
	output logic [TADDR_W-1:0]   target_address,
	output logic                 is_write,
	output logic [BYTE_W-1:0]    byte_data,
	output logic [BYTE_W-1:0]    read_constant,
	output logic                 last
);

	logic [ROM_ADDR_BITS-1:0] rom_offset_q;
	logic [EXT_W-1:0]         ext_offset_q;

	logic                     out_valid_q;
	tgt_t                     tgt_q;
	logic [TADDR_W-1:0]       taddr_q;
	logic                     is_write_q;
	logic [BYTE_W-1:0]        byte_data_q;
	logic [BYTE_W-1:0]        read_const_q;
	logic                     last_q;

	logic                     load;
	logic [TADDR_W-1:0]       taddr;
	logic [ROM_ADDR_BITS-1:0] rom_addr;
	logic [EXT_W-1:0]         ext_addr;

	assign load  = ~out_valid_q | ~out_stall;
	assign q_pop = load & ~q_status.empty;

	assign rom_addr = rom_offset_q | ROM_ADDR_BITS'(q_data.loc);
	assign ext_addr = ext_offset_q + EXT_W'(q_data.loc);

	always_comb begin
		unique case (q_data.tgt)
			TGT_ROM_BANKED: taddr = TADDR_W'(rom_addr);
			TGT_EXT_RAM:    taddr = TADDR_W'(ext_addr);
			default:        taddr = TADDR_W'(q_data.loc);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_offset_q <= ROM_ADDR_BITS'(ROM_OFFSET_RESET);
			ext_offset_q <= EXT_OFFSET_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROM_BANK_OFFSET: rom_offset_q <= cfg_data[ROM_ADDR_BITS-1:0];
				REG_EXT_RAM_OFFSET:  ext_offset_q <= cfg_data[EXT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= ~q_status.empty;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			tgt_q        <= q_data.tgt;
			taddr_q      <= taddr;
			is_write_q   <= q_data.is_write;
			byte_data_q  <= q_data.byte_data;
			read_const_q <= q_data.read_constant;
			last_q       <= q_data.last;
		end
	end

	assign out_valid      = out_valid_q;
	assign target         = tgt_q;
	assign target_address = taddr_q;
	assign is_write       = is_write_q;
	assign byte_data      = byte_data_q;
	assign read_constant  = read_const_q;
	assign last           = last_q;

endmodule

[src/handheld_bus_address_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_bus_address_decoder_unit
// Decodes CPU bus accesses into per-target byte beats with bank offsets.
// ----------------------------------------------------------------------------
// One byte beat leaves per clock while neither side stalls. A byte access
// makes one beat, a word access two: the front splits it into a low-byte
// beat at address and a high-byte beat at address+1 (wrapping at 0xFFFF),
// and emits one beat per cycle while the queue is not full. Each beat is
// written into the beat queue, the low byte as the access is taken, and then
// loaded into the result register, where it is valid; the high byte waits in
// the front's pending registers. The beat queue (QUEUE_DEPTH entries) and the
// result register let each side stall on its own; cfg writes are always ready.
// ----------------------------------------------------------------------------
module handheld_bus_address_decoder_unit
	import hbad_pkg::*;
#(
	parameter int unsigned ROM_ADDR_BITS = 23,
	parameter int unsigned QUEUE_DEPTH   = 4
)(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           func,
	input  logic [ADDR_W-1:0]    address,
	input  logic [DATA_W-1:0]    write_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output logic [4:0]           target,
	output logic [TADDR_W-1:0]   target_address,
	output logic                 is_write,
	output logic [BYTE_W-1:0]    byte_data,
	output logic [BYTE_W-1:0]    read_constant,
	output logic                 last,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	q_status_t q_status;
	logic      q_push;
	logic      q_pop;
	beat_t     q_wdata;
	beat_t     q_rdata;

	assign cfg_ready = 1'b1;

	hbad_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.func       (func),
		.address    (address),
		.write_data (write_data),
		.q_status   (q_status),
		.q_push     (q_push),
		.q_data     (q_wdata)
	);

	hbad_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_wdata),
		.pop       (q_pop),
		.pop_data  (q_rdata),
		.status    (q_status)
	);

	hbad_back #(
		.ROM_ADDR_BITS (ROM_ADDR_BITS)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_valid & cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.q_status       (q_status),
		.q_data         (q_rdata),
		.q_pop          (q_pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.target         (target),
		.target_address (target_address),
		.is_write       (is_write),
		.byte_data      (byte_data),
		.read_constant  (read_constant),
		.last           (last)
	);

endmodule

[src/hbad_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hbad_checker
// Port-level checks on the bus address decoder, bound to the top level.
// ----------------------------------------------------------------------------
module hbad_checker
	import hbad_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input logic [1:0]         func,
	input logic               out_valid,
	input logic               out_stall,
	input logic [4:0]         target,
	input logic [TADDR_W-1:0] target_address,
	input logic               is_write,
	input logic [BYTE_W-1:0]  byte_data,
	input logic [BYTE_W-1:0]  read_constant
);

	// hold a stalled result beat
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(target) &&
		$stable(target_address) && $stable(byte_data))
		else $error("stalled result beat changed");

	// stall the beat after a word access for its high byte
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && func[FUNC_WORD_BIT] |=> in_stall)
		else $error("word access did not hold the input for its second beat");

	// drop writes to holes and unimplemented registers
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && target == TGT_NONE |-> !is_write && byte_data == '0)
		else $error("write reached no target");

	// read constant only where there is no target
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && read_constant != '0 |-> target == TGT_NONE && !is_write)
		else $error("read constant on a real target");

endmodule

bind handheld_bus_address_decoder_unit hbad_checker u_hbad_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_stall       (in_stall),
	.func           (func),
	.out_valid      (out_valid),
	.out_stall      (out_stall),
	.target         (target),
	.target_address (target_address),
	.is_write       (is_write),
	.byte_data      (byte_data),
	.read_constant  (read_constant)
);

[tb/sv/handheld_bus_address_decoder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handheld_bus_address_decoder_unit_test
// Self-checking bench for the bus address decoder. A short directed table
// walks the region edges, every access type and the word wrap at 0xFFFF.
// Random accesses follow under several ROM and external RAM bank settings,
// the extremes among them. Every beat on the result channel is checked
// field by field against the table or a bench decoder model, with random
// idles on both sides and a long result hold that backs up the input.
// ----------------------------------------------------------------------------
module handheld_bus_address_decoder_unit_test;
	import hbad_pkg::*;

	localparam int unsigned ROM_BITS     = 23;
	localparam int unsigned CLK_HALF     = 6;
	localparam int unsigned RESET_CYCLES = 9;
	localparam int unsigned IDLE_PCT     = 23;
	localparam int unsigned HOLD_CYCLES  = 80;
	localparam int unsigned PHASE_ITEMS  = 120;
	localparam int unsigned BANK_PHASES  = 6;
	localparam int unsigned TAIL_CYCLES  = 8;
	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DIR_ROWS     = 25;

	localparam logic [TADDR_W-1:0] ROM_MASK    = TADDR_W'((64'd1 << ROM_BITS) - 1);
	localparam logic [CFG_W-1:0]   ROM_OFF_MAX = 23'h7FC000;
	localparam logic [EXT_W-1:0]   EXT_OFF_MAX = 17'h1E000;

	typedef enum logic [1:0] {
		F_RD_BYTE = 2'd0,
		F_WR_BYTE = 2'd1,
		F_RD_WORD = 2'd2,
		F_WR_WORD = 2'd3
	} access_t;

	typedef struct packed {
		tgt_t               tgt;
		logic [TADDR_W-1:0] taddr;
		logic               wr;
		logic [BYTE_W-1:0]  data;
		logic [BYTE_W-1:0]  rc;
		logic               fin;
	} bus_beat_t;

	typedef struct packed {
		access_t            f;
		logic [ADDR_W-1:0]  a;
		logic [DATA_W-1:0]  d;
		logic               typed;
		tgt_t               tgt;
		logic [TADDR_W-1:0] taddr;
		logic               wr;
		logic [BYTE_W-1:0]  data;
		logic [BYTE_W-1:0]  rc;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 in_valid;
	logic                 in_stall;
	logic [1:0]           func;
	logic [ADDR_W-1:0]    address;
	logic [DATA_W-1:0]    write_data;
	logic                 out_valid;
	logic                 out_stall;
	logic [4:0]           target;
	logic [TADDR_W-1:0]   target_address;
	logic                 is_write;
	logic [BYTE_W-1:0]    byte_data;
	logic [BYTE_W-1:0]    read_constant;
	logic                 last;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	logic [CFG_W-1:0] rom_offset;
	logic [EXT_W-1:0] ext_offset;
	bus_beat_t        pending_beats[$];
	dir_row_t         dir_rows[DIR_ROWS];

	int unsigned mismatches;
	int unsigned beats_checked;
	int unsigned accesses;
	int unsigned word_accesses;
	int unsigned cycles;
	bit          calm;
	bit          hold_req;
	bit          hold_active;

	handheld_bus_address_decoder_unit #(
		.ROM_ADDR_BITS(ROM_BITS)
	) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.func          (func),
		.address       (address),
		.write_data    (write_data),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.target        (target),
		.target_address(target_address),
		.is_write      (is_write),
		.byte_data     (byte_data),
		.read_constant (read_constant),
		.last          (last),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout after %0d cycles, %0d beats outstanding", $time, cycles,
				pending_beats.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic bus_beat_t decode_byte(input logic [ADDR_W-1:0] a, input logic wr,
			input logic [BYTE_W-1:0] d, input logic fin);
		bus_beat_t        b;
		logic [ADDR_W-1:0] off;
		logic [EXT_W-1:0]  ext_sum;
		b.tgt   = TGT_NONE;
		b.taddr = '0;
		b.rc    = '0;
		if (a < ADDR_ROM_BANKED) begin
			b.tgt   = wr ? TGT_BANK_CTRL : TGT_ROM_FIXED;
			b.taddr = TADDR_W'(a);
		end else if (a < ADDR_VRAM) begin
			if (wr) begin
				b.tgt   = TGT_BANK_CTRL;
				b.taddr = TADDR_W'(a);
			end else begin
				off     = a - ADDR_ROM_BANKED;
				b.tgt   = TGT_ROM_BANKED;
				b.taddr = (rom_offset | TADDR_W'(off)) & ROM_MASK;
			end
		end else if (a < ADDR_EXT_RAM) begin
			b.tgt   = TGT_VRAM;
			b.taddr = TADDR_W'(a - ADDR_VRAM);
		end else if (a < ADDR_WRAM) begin
			off     = a - ADDR_EXT_RAM;
			ext_sum = ext_offset + EXT_W'(off);
			b.tgt   = TGT_EXT_RAM;
			b.taddr = TADDR_W'(ext_sum);
		end else if (a < ADDR_ECHO) begin
			b.tgt   = TGT_WRAM;
			b.taddr = TADDR_W'(a - ADDR_WRAM);
		end else if (a < ADDR_OAM) begin
			b.tgt   = TGT_WRAM;
			b.taddr = TADDR_W'(a - ADDR_ECHO);
		end else if (a < ADDR_UNUSABLE) begin
			b.tgt   = TGT_OAM;
			b.taddr = TADDR_W'(a - ADDR_OAM);
		end else if (a < ADDR_IO) begin
			b.rc = READ_HOLE;
		end else if (a < ADDR_VIDEO) begin
			case (a[BYTE_W-1:0])
				IO_JOYPAD: b.tgt = TGT_JOYPAD;
				IO_SB, IO_SC: begin
					b.tgt   = TGT_SERIAL;
					b.taddr = TADDR_W'(a[BYTE_W-1:0] - IO_SB);
				end
				IO_DIV:  b.tgt = TGT_DIV;
				IO_TIMA: b.tgt = TGT_TIMA;
				IO_TMA:  b.tgt = TGT_TMA;
				IO_TAC:  b.tgt = TGT_TAC;
				IO_IF:   b.tgt = TGT_IF;
				default: b.rc = READ_UNIMPL;
			endcase
		end else if (a < ADDR_VIDEO_END) begin
			b.tgt   = TGT_VIDEO;
			b.taddr = TADDR_W'(a - ADDR_VIDEO);
		end else if (a < ADDR_HRAM) begin
			b.rc = READ_HOLE;
		end else if (a < ADDR_IE) begin
			b.tgt   = TGT_HRAM;
			b.taddr = TADDR_W'(a - ADDR_HRAM);
		end else begin
			b.tgt = TGT_IE;
		end
		b.wr   = wr && (b.tgt != TGT_NONE);
		b.data = b.wr ? d : '0;
		b.fin  = fin;
		return b;
	endfunction

	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] edges[12];
		logic [ADDR_W-1:0] a;
		edges = '{ADDR_ROM_BANKED, ADDR_VRAM, ADDR_EXT_RAM, ADDR_WRAM, ADDR_ECHO,
			ADDR_OAM, ADDR_UNUSABLE, ADDR_IO, ADDR_VIDEO, ADDR_VIDEO_END, ADDR_HRAM,
			ADDR_IE};
		case ($urandom_range(0, 9))
			0:       a = ADDR_W'($urandom);
			1:       a = ADDR_W'($urandom_range(16'h0000, 16'h7FFF));
			2:       a = ADDR_W'($urandom_range(16'h8000, 16'hBFFF));
			3:       a = ADDR_W'($urandom_range(16'hC000, 16'hFDFF));
			4:       a = ADDR_W'($urandom_range(16'hFE00, 16'hFEFF));
			5, 6:    a = ADDR_W'($urandom_range(16'hFF00, 16'hFF4F));
			7:       a = ADDR_W'($urandom_range(16'hFF40, 16'hFFFF));
			8:       a = edges[$urandom_range(0, 11)] + ADDR_W'($urandom_range(0, 2)) - 16'd1;
			default: a = ADDR_W'($urandom_range(16'hFF80, 16'hFFFF));
		endcase
		return a;
	endfunction

	task automatic check_field(input string name, input logic [TADDR_W-1:0] want,
			input logic [TADDR_W-1:0] got);
		if (got !== want) begin
			mismatches++;
			$display("%0t %s mismatch: expected %h, actual %h", $time, name, want, got);
		end
	endtask

	always @(posedge clk) begin : check_beats
		bus_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_beats.size() == 0) begin
				mismatches++;
				$display("%0t unexpected beat: expected none, actual target %0d addr %h",
					$time, target, target_address);
			end else begin
				want = pending_beats.pop_front();
				beats_checked++;
				check_field("target", TADDR_W'(want.tgt), TADDR_W'(target));
				check_field("target_address", want.taddr, target_address);
				check_field("is_write", TADDR_W'(want.wr), TADDR_W'(is_write));
				check_field("byte_data", TADDR_W'(want.data), TADDR_W'(byte_data));
				check_field("read_constant", TADDR_W'(want.rc), TADDR_W'(read_constant));
				check_field("last", TADDR_W'(want.fin), TADDR_W'(last));
			end
		end
	end

	initial begin
		out_stall   = 1'b0;
		hold_active = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req    = 1'b0;
				hold_active = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_active = 1'b0;
			end
			out_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
		end
	end

	// Called at a falling edge; returns at the falling edge after the access is taken.
	task automatic issue_access(input access_t f, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d, input logic use_typed, input bus_beat_t typed_beat);
		logic wr;
		wr = f[FUNC_WRITE_BIT];
		while (!calm && !hold_active && $urandom_range(0, 99) < IDLE_PCT) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		func       <= f;
		address    <= a;
		write_data <= d;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		accesses++;
		if (use_typed) begin
			pending_beats.push_back(typed_beat);
		end else if (f[FUNC_WORD_BIT]) begin
			word_accesses++;
			pending_beats.push_back(decode_byte(a, wr, d[7:0], 1'b0));
			pending_beats.push_back(decode_byte(a + 16'd1, wr, d[15:8], 1'b1));
		end else begin
			pending_beats.push_back(decode_byte(a, wr, d[7:0], 1'b1));
		end
		@(negedge clk);
	endtask

	// Called at a falling edge; returns at the falling edge after dropping valid.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		if (idx == REG_ROM_BANK_OFFSET)
			rom_offset = val;
		else
			ext_offset = val[EXT_W-1:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_beats.size() != 0) @(negedge clk);
	endtask

	initial begin : stimulus
		bus_beat_t         typed;
		logic [CFG_W-1:0]  rom_val;
		logic [CFG_W-1:0]  ext_val;
		access_t           f;
		mismatches    = 0;
		beats_checked = 0;
		accesses      = 0;
		word_accesses = 0;
		cycles        = 0;
		calm          = 1'b0;
		hold_req      = 1'b0;
		rom_offset    = ROM_OFFSET_RESET;
		ext_offset    = EXT_OFFSET_RESET;
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		func          = F_RD_BYTE;
		address       = '0;
		write_data    = '0;
		cfg_valid     = 1'b0;
		cfg_index     = REG_ROM_BANK_OFFSET;
		cfg_data      = '0;

		dir_rows = '{
			'{F_RD_BYTE, 16'h0000, 16'h0000, 1'b1, TGT_ROM_FIXED,  23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_WR_BYTE, 16'h3FFF, 16'h00A5, 1'b1, TGT_BANK_CTRL,  23'h3FFF, 1'b1, 8'hA5, 8'h00},
			'{F_RD_BYTE, 16'h4000, 16'hFFFF, 1'b1, TGT_ROM_BANKED, 23'h4000, 1'b0, 8'h00, 8'h00},
			'{F_WR_BYTE, 16'h7FFF, 16'hFF5A, 1'b1, TGT_BANK_CTRL,  23'h7FFF, 1'b1, 8'h5A, 8'h00},
			'{F_RD_BYTE, 16'h7FFF, 16'h0000, 1'b1, TGT_ROM_BANKED, 23'h7FFF, 1'b0, 8'h00, 8'h00},
			'{F_RD_BYTE, 16'h8000, 16'h0000, 1'b1, TGT_VRAM,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_WR_WORD, 16'h9FFF, 16'h1234, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_RD_BYTE, 16'hBFFF, 16'h0000, 1'b1, TGT_EXT_RAM,    23'h1FFF, 1'b0, 8'h00, 8'h00},
			'{F_WR_BYTE, 16'hC000, 16'h00FF, 1'b1, TGT_WRAM,       23'h0000, 1'b1, 8'hFF, 8'h00},
			'{F_RD_BYTE, 16'hE000, 16'h0000, 1'b1, TGT_WRAM,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_RD_BYTE, 16'hFDFF, 16'h0000, 1'b1, TGT_WRAM,       23'h1DFF, 1'b0, 8'h00, 8'h00},
			'{F_WR_BYTE, 16'hFE9F, 16'h0081, 1'b1, TGT_OAM,        23'h009F, 1'b1, 8'h81, 8'h00},
			'{F_WR_BYTE, 16'hFEA0, 16'h00C3, 1'b1, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'hFF},
			'{F_RD_WORD, 16'hFF00, 16'h0000, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_WR_WORD, 16'hFF02, 16'hBEEF, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_RD_WORD, 16'hFF04, 16'h0000, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_WR_WORD, 16'hFF06, 16'h55AA, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_RD_BYTE, 16'hFF0F, 16'h0000, 1'b1, TGT_IF,         23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_WR_BYTE, 16'hFF10, 16'h0077, 1'b1, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_RD_WORD, 16'hFF3F, 16'h0000, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_WR_WORD, 16'hFF4B, 16'h6699, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_RD_BYTE, 16'hFF7F, 16'h0000, 1'b1, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'hFF},
			'{F_WR_WORD, 16'hFFFE, 16'hA55A, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_RD_WORD, 16'hFFFF, 16'h0000, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00},
			'{F_WR_WORD, 16'hFFFF, 16'hFFFF, 1'b0, TGT_NONE,       23'h0000, 1'b0, 8'h00, 8'h00}
		};

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset bank settings
		foreach (dir_rows[i]) begin
			typed.tgt   = dir_rows[i].tgt;
			typed.taddr = dir_rows[i].taddr;
			typed.wr    = dir_rows[i].wr;
			typed.data  = dir_rows[i].data;
			typed.rc    = dir_rows[i].rc;
			typed.fin   = 1'b1;
			issue_access(dir_rows[i].f, dir_rows[i].a, dir_rows[i].d, dir_rows[i].typed, typed);
		end
		drain();

		for (int p = 0; p < BANK_PHASES; p++) begin
			case (p)
				0: begin
					rom_val = ROM_OFF_MAX;
					ext_val = CFG_W'(EXT_OFF_MAX);
				end
				1: begin
					rom_val = '0;
					ext_val = '0;
				end
				default: begin
					if (p % 2 == 0) begin
						rom_val = CFG_W'($urandom_range(0, ROM_OFF_MAX));
						ext_val = CFG_W'($urandom_range(0, EXT_OFF_MAX));
					end else begin
						rom_val = {9'($urandom_range(0, 511)), 14'h0};
						ext_val = CFG_W'({4'($urandom_range(0, 15)), 13'h0});
					end
				end
			endcase
			write_reg(REG_ROM_BANK_OFFSET, rom_val);
			write_reg(REG_EXT_RAM_OFFSET, ext_val);
			calm     = (p == 1);
			hold_req = (p == 2);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				f = access_t'($urandom_range(0, 3));
				issue_access(f, pick_address(), DATA_W'($urandom), 1'b0, '0);
			end
			drain();
		end
		calm = 1'b0;

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Covered %0d accesses (%0d word) over %0d bank settings plus reset values",
			accesses, word_accesses, BANK_PHASES);
		$display("Checked %0d beats, %0d field mismatches", beats_checked, mismatches);
		if (mismatches == 0 && pending_beats.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
